// ----- hw/rtl/bba_pkg.sv -----
package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF    = 4096;
  localparam int unsigned MAP_WORD_BITS_DEF = 32;

  localparam int unsigned TOTAL_W  = 13;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 13;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd2880;
  localparam int unsigned        FIRST_ALLOC = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_FORMAT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_IS_ALLOC,
    COND_IS_FREE,
    COND_IS_FORMAT,
    COND_IDX_BAD,
    COND_SCAN_MORE,
    COND_NO_HIT,
    COND_CLR_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_ZERO,
    ADDR_INC,
    ADDR_IDX
  } addr_op_e;

  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_HIT,
    WR_FREE
  } wsrc_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_DEC,
    CNT_INC,
    CNT_FMT
  } cnt_op_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_CLEAR,
    RES_NO_FREE,
    RES_RANGE,
    RES_GRANT
  } res_op_e;

  localparam int unsigned PC_W = 5;

  localparam logic [PC_W-1:0] STEP_FMT      = 5'd0;
  localparam logic [PC_W-1:0] STEP_CLR      = 5'd1;
  localparam logic [PC_W-1:0] STEP_EMIT     = 5'd2;
  localparam logic [PC_W-1:0] STEP_IDLE     = 5'd3;
  localparam logic [PC_W-1:0] STEP_DISP     = 5'd4;
  localparam logic [PC_W-1:0] STEP_DISP_FR  = 5'd5;
  localparam logic [PC_W-1:0] STEP_DISP_FMT = 5'd6;
  localparam logic [PC_W-1:0] STEP_NOP      = 5'd7;
  localparam logic [PC_W-1:0] STEP_A_START  = 5'd8;
  localparam logic [PC_W-1:0] STEP_A_PRIME  = 5'd9;
  localparam logic [PC_W-1:0] STEP_A_SCAN   = 5'd10;
  localparam logic [PC_W-1:0] STEP_A_CHECK  = 5'd11;
  localparam logic [PC_W-1:0] STEP_A_SET    = 5'd12;
  localparam logic [PC_W-1:0] STEP_F_START  = 5'd13;
  localparam logic [PC_W-1:0] STEP_F_READ   = 5'd14;
  localparam logic [PC_W-1:0] STEP_F_WRITE  = 5'd15;
  localparam logic [PC_W-1:0] STEP_F_BAD    = 5'd16;

  typedef struct packed {
    cond_e            cond;
    logic [PC_W-1:0]  target;
    logic             ready;
    addr_op_e         addr_op;
    logic             wr_en;
    wsrc_e            wsrc;
    cnt_op_e          cnt_op;
    res_op_e          res_op;
    logic             scan;
    logic             emit;
  } ctrl_t;

  typedef struct packed {
    logic req;
    cmd_e cmd;
    logic idx_bad;
    logic scan_more;
    logic hit;
    logic clr_more;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    c.cond    = COND_NEVER;
    c.target  = STEP_IDLE;
    c.addr_op = ADDR_HOLD;
    c.wsrc    = WR_CLEAR;
    c.cnt_op  = CNT_HOLD;
    c.res_op  = RES_HOLD;
    case (pc)
      STEP_FMT: begin
        c.addr_op = ADDR_ZERO;
        c.cnt_op  = CNT_FMT;
        c.res_op  = RES_CLEAR;
      end
      STEP_CLR: begin
        c.wr_en   = 1'b1;
        c.wsrc    = WR_CLEAR;
        c.addr_op = ADDR_INC;
        c.cond    = COND_CLR_MORE;
        c.target  = STEP_CLR;
      end
      STEP_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.target = STEP_EMIT;
      end
      STEP_IDLE: begin
        c.ready  = 1'b1;
        c.cond   = COND_NO_REQ;
        c.target = STEP_IDLE;
      end
      STEP_DISP: begin
        c.res_op = RES_CLEAR;
        c.cond   = COND_IS_ALLOC;
        c.target = STEP_A_START;
      end
      STEP_DISP_FR: begin
        c.cond   = COND_IS_FREE;
        c.target = STEP_F_START;
      end
      STEP_DISP_FMT: begin
        c.cond   = COND_IS_FORMAT;
        c.target = STEP_FMT;
      end
      STEP_NOP: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_EMIT;
      end
      STEP_A_START: begin
        c.addr_op = ADDR_ZERO;
        c.res_op  = RES_NO_FREE;
      end
      STEP_A_PRIME: begin
        c.addr_op = ADDR_INC;
      end
      STEP_A_SCAN: begin
        c.addr_op = ADDR_INC;
        c.scan    = 1'b1;
        c.cond    = COND_SCAN_MORE;
        c.target  = STEP_A_SCAN;
      end
      STEP_A_CHECK: begin
        c.cond   = COND_NO_HIT;
        c.target = STEP_EMIT;
      end
      STEP_A_SET: begin
        c.wr_en  = 1'b1;
        c.wsrc   = WR_HIT;
        c.cnt_op = CNT_DEC;
        c.res_op = RES_GRANT;
        c.cond   = COND_ALWAYS;
        c.target = STEP_EMIT;
      end
      STEP_F_START: begin
        c.addr_op = ADDR_IDX;
        c.cond    = COND_IDX_BAD;
        c.target  = STEP_F_BAD;
      end
      STEP_F_READ: begin
        c.cond = COND_NEVER;
      end
      STEP_F_WRITE: begin
        c.wr_en  = 1'b1;
        c.wsrc   = WR_FREE;
        c.cnt_op = CNT_INC;
        c.cond   = COND_ALWAYS;
        c.target = STEP_EMIT;
      end
      STEP_F_BAD: begin
        c.res_op = RES_RANGE;
        c.cond   = COND_ALWAYS;
        c.target = STEP_EMIT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/bba_ram.sv -----
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bba_seq.sv -----
module bba_seq import bba_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  ctrl_t           ctrl;
  logic            take;

  assign ctrl   = ucode(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_REQ:    take = !flags_i.req;
      COND_IS_ALLOC:  take = (flags_i.cmd == CMD_ALLOC);
      COND_IS_FREE:   take = (flags_i.cmd == CMD_FREE);
      COND_IS_FORMAT: take = (flags_i.cmd == CMD_FORMAT);
      COND_IDX_BAD:   take = flags_i.idx_bad;
      COND_SCAN_MORE: take = flags_i.scan_more;
      COND_NO_HIT:    take = !flags_i.hit;
      COND_CLR_MORE:  take = flags_i.clr_more;
      COND_OUT_BUSY:  take = flags_i.out_busy;
      default:        take = 1'b0;
    endcase
    pc_d = take ? ctrl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FMT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/bba_datapath.sv -----
module bba_datapath import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int unsigned MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  output flags_t              flags_o,
  input  logic [TOTAL_W-1:0]  blk_total_i,
  input  logic                in_valid_i,
  input  logic [CMD_W-1:0]    in_command_i,
  input  logic [IDX_W-1:0]    in_block_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [IDX_W-1:0]    out_granted_block_o,
  output logic [COUNT_W-1:0]  out_free_count_o
);

  localparam int unsigned W         = MAP_WORD_BITS;
  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + W - 1) / W;
  localparam int unsigned AW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW        = $clog2(W);
  localparam int unsigned IW_MAP    = $clog2(MAP_WORDS * W + 1);
  localparam int unsigned IW        = IW_MAP > TOTAL_W ? IW_MAP : TOTAL_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [W-1:0]  RESERVED_BITS = W'(3);

  logic [AW-1:0]      addr_q;
  logic [AW-1:0]      addr_d;
  logic [AW-1:0]      rd_addr_q;
  logic [AW-1:0]      waddr;
  logic [W-1:0]       wdata;
  logic [W-1:0]       rdata;
  cmd_e               cmd_q;
  logic [IW-1:0]      idx_q;
  logic               hit_q;
  logic [AW-1:0]      hit_word_q;
  logic [BW-1:0]      hit_bit_q;
  logic [W-1:0]       hit_data_q;
  logic [COUNT_W-1:0] count_q;
  status_e            status_q;
  logic [IDX_W-1:0]   grant_q;
  logic               init_q;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [IDX_W-1:0]   out_grant_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [IW-1:0]      tot_ext;
  logic [IW-1:0]      eff_tot;
  logic [TOTAL_W-1:0] tot;
  logic [IW-1:0]      base;
  logic [IW:0]        diff;
  logic               rem_neg;
  logic [W-1:0]       cand;
  logic               found;
  logic [BW-1:0]      found_bit;
  logic [IW-1:0]      grant_full;
  logic               out_busy;
  logic               accept;

  assign tot_ext = IW'(blk_total_i);
  assign eff_tot = (tot_ext > IW'(MAX_BLOCKS)) ? IW'(MAX_BLOCKS) : tot_ext;
  assign tot     = eff_tot[TOTAL_W-1:0];

  assign base    = IW'({rd_addr_q, {BW{1'b0}}});
  assign diff    = {1'b0, eff_tot} - {1'b0, base};
  assign rem_neg = diff[IW];

  always_comb begin
    for (int j = 0; j < W; j++) begin
      cand[j] = !rdata[j] && ((rd_addr_q != '0) || (j >= FIRST_ALLOC)) &&
                !rem_neg && (diff[IW-1:0] > IW'(j));
    end
    found     = 1'b0;
    found_bit = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found     = 1'b1;
        found_bit = BW'(j);
      end
    end
  end

  assign grant_full = IW'({hit_word_q, hit_bit_q});
  assign out_busy   = out_valid_q && !out_ready_i && !init_q;
  assign accept     = ctrl_i.ready && in_valid_i;

  assign flags_o.req       = in_valid_i;
  assign flags_o.cmd       = cmd_q;
  assign flags_o.idx_bad   = !(idx_q < eff_tot);
  assign flags_o.scan_more = !found && !rem_neg && (diff[IW-1:0] > IW'(W)) &&
                             (rd_addr_q != LAST_WORD);
  assign flags_o.hit       = hit_q;
  assign flags_o.clr_more  = (addr_q != LAST_WORD);
  assign flags_o.out_busy  = out_busy;

  always_comb begin
    case (ctrl_i.addr_op)
      ADDR_HOLD: addr_d = addr_q;
      ADDR_ZERO: addr_d = '0;
      ADDR_INC:  addr_d = addr_q + 1'b1;
      ADDR_IDX:  addr_d = idx_q[BW +: AW];
      default:   addr_d = addr_q;
    endcase
  end

  always_comb begin
    waddr = addr_q;
    case (ctrl_i.wsrc)
      WR_CLEAR: wdata = (addr_q == '0) ? RESERVED_BITS : '0;
      WR_HIT: begin
        wdata = hit_data_q;
        waddr = hit_word_q;
      end
      WR_FREE:  wdata = rdata & ~(W'(1) << idx_q[BW-1:0]);
      default:  wdata = '0;
    endcase
  end

  bba_ram #(
    .WIDTH (W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    rd_addr_q <= addr_q;
    if (accept) begin
      cmd_q <= cmd_e'(in_command_i);
      idx_q <= IW'(in_block_index_i);
    end
    if (ctrl_i.scan) begin
      hit_word_q <= rd_addr_q;
      hit_bit_q  <= found_bit;
      hit_data_q <= rdata | (W'(1) << found_bit);
    end
    case (ctrl_i.res_op)
      RES_HOLD: ;
      RES_CLEAR: begin
        status_q <= ST_DONE;
        grant_q  <= '0;
      end
      RES_NO_FREE: begin
        status_q <= ST_NO_FREE;
        grant_q  <= '0;
      end
      RES_RANGE: begin
        status_q <= ST_RANGE;
        grant_q  <= '0;
      end
      RES_GRANT: begin
        status_q <= ST_DONE;
        grant_q  <= grant_full[IDX_W-1:0];
      end
      default: ;
    endcase
    if (ctrl_i.emit && !out_busy && !init_q) begin
      out_status_q <= status_q;
      out_grant_q  <= grant_q;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      hit_q       <= 1'b0;
      count_q     <= TOTAL_RESET - COUNT_W'(FIRST_ALLOC);
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      addr_q <= addr_d;
      if (ctrl_i.scan) begin
        hit_q <= found;
      end
      case (ctrl_i.cnt_op)
        CNT_HOLD: ;
        CNT_DEC: begin
          if (count_q != '0) begin
            count_q <= count_q - 1'b1;
          end
        end
        CNT_INC: begin
          if (count_q < tot) begin
            count_q <= count_q + 1'b1;
          end
        end
        CNT_FMT: begin
          count_q <= (tot >= TOTAL_W'(FIRST_ALLOC)) ? tot - TOTAL_W'(FIRST_ALLOC) : '0;
        end
        default: ;
      endcase
      if (ctrl_i.emit && !out_busy) begin
        if (init_q) begin
          init_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_granted_block_o = out_grant_q;
  assign out_free_count_o    = out_count_q;

endmodule

// ----- hw/rtl/block_bitmap_allocator.sv -----
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser command, tdata block_index
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata granted, count
// apb       in/out     psel, penable, pready         block total register at 0x0
//
// One request is worked on at a time by a microcoded step sequencer.
// Allocate scans the bitmap words in order (at most MAP_WORDS, 128 by default),
// one word per cycle through the map RAM read port.
// Format clears all MAP_WORDS words, one word written per cycle.
// After reset the map is cleared by a pass over all MAP_WORDS words with s_axis_tready low.
// A new request is taken while a result waits in the output register.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS    = MAX_BLOCKS_DEF,
  parameter int unsigned MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] block_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] granted_block, [24:12] free_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam logic REG_BLK_TOTAL = 1'b0;

  logic [TOTAL_W-1:0] total_q;
  ctrl_t              ctrl;
  flags_t             flags;
  logic [IDX_W-1:0]   granted;
  logic [COUNT_W-1:0] free_count;
  logic [STATUS_W-1:0] status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLK_TOTAL) ? 32'(total_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BLK_TOTAL)) begin
      total_q <= pwdata[TOTAL_W-1:0];
    end
  end

  bba_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  bba_datapath #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .ctrl_i              (ctrl),
    .flags_o             (flags),
    .blk_total_i         (total_q),
    .in_valid_i          (s_axis_tvalid),
    .in_command_i        (s_axis_tuser),
    .in_block_index_i    (s_axis_tdata[IDX_W-1:0]),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .out_status_o        (status),
    .out_granted_block_o (granted),
    .out_free_count_o    (free_count)
  );

  assign s_axis_tready = ctrl.ready;
  assign m_axis_tuser  = status;
  assign m_axis_tdata  = {7'b0, free_count, granted};

endmodule
